// ===== sv/dzpd_pkg.sv =====
package dzpd_pkg;

    localparam int unsigned DIST_W  = 16;
    localparam int unsigned FILL_W  = 3;
    localparam int unsigned SLOT_W  = 2;
    localparam int unsigned NUM_SLOTS = 3;

    // apb register map, one 32-bit word per register
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_MIN_VALID = 1'b1;

    localparam logic [DIST_W-1:0] THRESHOLD_RESET = 16'd1700;
    localparam logic [DIST_W-1:0] MIN_VALID_RESET = 16'd40;

    // path fill runs from start to full
    localparam logic [FILL_W-1:0] FILL_START = 3'd1;
    localparam logic [FILL_W-1:0] FILL_FULL  = 3'd4;
    localparam logic [FILL_W-1:0] FILL_SLOT_BASE = 3'd2;

    // combined occupancy codes, bit0 left, bit1 right
    localparam logic [SLOT_W-1:0] OCC_LEFT  = 2'd1;
    localparam logic [SLOT_W-1:0] OCC_RIGHT = 2'd2;
    localparam logic [SLOT_W-1:0] OCC_BOTH  = 2'd3;

    typedef enum logic [1:0] {
        PASSAGE_NONE = 2'd0,
        PASSAGE_IN   = 2'd1,
        PASSAGE_OUT  = 2'd2
    } passage_t;

    typedef logic [SLOT_W-1:0] slot_t;

endpackage

// ===== sv/dzpd_occ.sv =====
// zone occupancy classification of one reading
module dzpd_occ (
    input  logic [dzpd_pkg::DIST_W-1:0] distance_mm,
    input  logic [dzpd_pkg::DIST_W-1:0] presence_threshold_mm,
    input  logic [dzpd_pkg::DIST_W-1:0] floor_mm,
    output logic                        occupied
);
    import dzpd_pkg::*;

    logic above_min;
    logic below_thr;

    assign above_min = distance_mm > floor_mm;
    assign below_thr = distance_mm < presence_threshold_mm;

    // msb set on either side reads as negative in the signed view
    assign occupied = !distance_mm[DIST_W-1] && !presence_threshold_mm[DIST_W-1]
                      && above_min && below_thr;

endmodule

// ===== sv/dual_zone_passage_direction.sv =====
// a request accepted at one edge shows its passage on m_ outputs after that edge,
//   through the result register
// throughput: one request per cycle; s_ready drops only while a result waits on m_ready
// reset: synchronous active-low aresetn clears both zones, sets path fill to 1,
//   restores register defaults and empties the result register
module dual_zone_passage_direction (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dzpd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [dzpd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [dzpd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [dzpd_pkg::DIST_W-1:0]         s_distance_mm,
    input  logic                                s_zone_right,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_passage
);
    import dzpd_pkg::*;

    logic [DIST_W-1:0] threshold_reg;
    logic [DIST_W-1:0] min_valid_reg;
    logic              left_occ_reg, left_occ_next;
    logic              right_occ_reg, right_occ_next;
    slot_t             slots_reg [NUM_SLOTS];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              m_valid_reg;
    passage_t          passage_reg, passage_next;

    logic              cur_occ;
    logic              changed;
    logic              both_empty;
    slot_t             status;
    logic [FILL_W-1:0] fill_inc;
    logic [FILL_W-1:0] slot_off;
    logic              s_accept;
    logic              cfg_write;

    dzpd_occ u_occ (
        .distance_mm           (s_distance_mm),
        .presence_threshold_mm (threshold_reg),
        .floor_mm              (min_valid_reg),
        .occupied              (cur_occ)
    );

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_passage = passage_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_THRESHOLD: prdata[DIST_W-1:0] = threshold_reg;
            REG_MIN_VALID: prdata[DIST_W-1:0] = min_valid_reg;
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        left_occ_next  = left_occ_reg;
        right_occ_next = right_occ_reg;
        changed        = 1'b0;
        if (s_zone_right) begin
            right_occ_next = cur_occ;
            changed        = cur_occ != right_occ_reg;
        end else begin
            left_occ_next = cur_occ;
            changed       = cur_occ != left_occ_reg;
        end
        status     = {right_occ_next, left_occ_next};
        both_empty = !left_occ_next && !right_occ_next;
        fill_inc   = (fill_reg < FILL_FULL) ? fill_reg + FILL_START : fill_reg;
        slot_off   = fill_inc - FILL_SLOT_BASE;

        fill_next    = fill_reg;
        passage_next = PASSAGE_NONE;
        if (changed) begin
            if (both_empty) begin
                fill_next = FILL_START;
                if (fill_inc == FILL_FULL) begin
                    if (slots_reg[0] == OCC_LEFT && slots_reg[1] == OCC_BOTH
                            && slots_reg[2] == OCC_RIGHT) begin
                        passage_next = PASSAGE_IN;
                    end else if (slots_reg[0] == OCC_RIGHT && slots_reg[1] == OCC_BOTH
                            && slots_reg[2] == OCC_LEFT) begin
                        passage_next = PASSAGE_OUT;
                    end
                end
            end else begin
                fill_next = fill_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
            min_valid_reg <= MIN_VALID_RESET;
            left_occ_reg  <= 1'b0;
            right_occ_reg <= 1'b0;
            fill_reg      <= FILL_START;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slots_reg[i] <= '0;
            end
        end else begin
            if (cfg_write) begin
                unique case (paddr[2])
                    REG_THRESHOLD: threshold_reg <= pwdata[DIST_W-1:0];
                    REG_MIN_VALID: min_valid_reg <= pwdata[DIST_W-1:0];
                    default: ;
                endcase
            end
            if (s_accept) begin
                left_occ_reg  <= left_occ_next;
                right_occ_reg <= right_occ_next;
                fill_reg      <= fill_next;
                // on a change that leaves a zone occupied, write slot (fill-1), or slot 2 once fill is full
                if (changed && !both_empty) begin
                    slots_reg[slot_off[1:0]] <= status;
                end
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            passage_reg <= passage_next;
        end
    end

endmodule

// ===== sv/dzpd_checker.sv =====
module dzpd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_passage
);
    import dzpd_pkg::*;

    // result register empties under reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an accepted request always produces a result next cycle
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted request gave no result");

    // an empty result register never stalls the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_passage_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_passage == PASSAGE_NONE || m_passage == PASSAGE_IN
                     || m_passage == PASSAGE_OUT))
        else $error("undefined passage code");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_passage))
        else $error("stalled result changed");

endmodule

bind dual_zone_passage_direction dzpd_checker u_dzpd_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_passage (m_passage)
);
